@@ design/shmx_pkg.sv @@
// ---------------------------------------------------------------------------
// shmx_pkg: shared types and constants
// SHA-256 constants, message tag and the descriptor passed front to back.
// ---------------------------------------------------------------------------
package shmx_pkg;

	localparam logic [15:0] MOD_RESET = 16'd12289;

	// The 26-byte tag is fixed and starts the message: words 0..5
	// hold tag bytes 0..23, word 6 holds tag bytes 24,25 then nonce bytes 0,1.
	localparam logic [31:0] TAG_W0 = 32'h4e544c2d;
	localparam logic [31:0] TAG_W1 = 32'h6c617474;
	localparam logic [31:0] TAG_W2 = 32'h6963652d;
	localparam logic [31:0] TAG_W3 = 32'h68617368;
	localparam logic [31:0] TAG_W4 = 32'h2d746f2d;
	localparam logic [31:0] TAG_W5 = 32'h6d617472;
	localparam logic [15:0] TAG_TAIL = 16'h6978;
	localparam logic [31:0] LEN_BITS = 32'h00000150;

	typedef struct packed {
		logic [63:0] nonce;
		logic [63:0] block_counter;
		logic [4:0]  count;
	} desc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_EMIT
	} bk_state_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_RUN
	} rd_state_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int s);
		ror = (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
			32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
			32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
			32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
			32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
			32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
			32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
			32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
			32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
			32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
			32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
		};
		round_k = k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		case (i)
			3'd0: init_h = 32'h6a09e667;
			3'd1: init_h = 32'hbb67ae85;
			3'd2: init_h = 32'h3c6ef372;
			3'd3: init_h = 32'ha54ff53a;
			3'd4: init_h = 32'h510e527f;
			3'd5: init_h = 32'h9b05688c;
			3'd6: init_h = 32'h1f83d9ab;
			default: init_h = 32'h5be0cd19;
		endcase
	endfunction

endpackage

@@ design/sha256_hash_to_matrix_expander_unit.sv @@
// ---------------------------------------------------------------------------
// sha256_hash_to_matrix_expander_unit: SHA-256 counter-mode element expander
// Hashes tag|nonce|counter and emits up to 16 digest halfwords modulo q.
// ---------------------------------------------------------------------------
// Flow: queue handoff, 64 compression rounds, then for each element the reducer
// start, 16-step serial reduction and done register before the output register.
// The next element starts only after the previous one leaves the output
// register, so elements do not overlap. The round loop and the bit-serial
// reducer set the pace. A two-entry queue decouples input.
// Reset: arst_n clears control state and loads modulus with 12289.
module sha256_hash_to_matrix_expander_unit import shmx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [63:0] nonce, [127:64] block_counter, [132:128] elements_wanted, pad
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] element
	output logic [15:0]  m_axis_tdata,
	output logic         m_axis_tlast
);

	logic [15:0] mod_q;
	logic        q_valid;
	logic        q_take;
	desc_t       q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= MOD_RESET;
		else if (cfg_we) mod_q <= cfg_wdata;
	end

	shmx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_nonce(s_axis_tdata[63:0]), .in_counter(s_axis_tdata[127:64]),
		.in_wanted(s_axis_tdata[132:128]),
		.q_valid(q_valid), .q_take(q_take), .q_head(q_head)
	);

	shmx_back u_back (
		.clk(clk), .arst_n(arst_n), .modulus(mod_q), .q_valid(q_valid),
		.q_take(q_take), .q_head(q_head), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_element(m_axis_tdata), .out_last(m_axis_tlast)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("queue popped while empty");
	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mod_q != 16'd0 |-> m_axis_tdata < mod_q || $past(cfg_we))
		else $error("element not reduced");
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> q_head.count != 5'd0 && q_head.count <= 5'd16)
		else $error("bad queued count");

endmodule

@@ design/shmx_front.sv @@
// ---------------------------------------------------------------------------
// shmx_front: input stage
// Accepts items, saturates the count, drops zero-count items, and keeps a
// two-entry queue of descriptors for the back end.
// ---------------------------------------------------------------------------
module shmx_front import shmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] in_nonce,
	input  logic [63:0] in_counter,
	input  logic [4:0]  in_wanted,
	output logic        q_valid,
	input  logic        q_take,
	output desc_t       q_head
);

	desc_t       ent_q [2];
	logic        rd_q;
	logic        wr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic [4:0]  sat;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = ent_q[rd_q];
	assign sat      = (in_wanted > 5'd16) ? 5'd16 : in_wanted;
	// zero-count items produce nothing: drop them here
	assign push     = in_valid && in_ready && (in_wanted != 5'd0);
	assign pop      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= '{nonce: in_nonce, block_counter: in_counter, count: sat};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ design/shmx_reduce.sv @@
// ---------------------------------------------------------------------------
// shmx_reduce: iterative modular reduction
// Restoring reduction of a 16-bit word by q, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module shmx_reduce import shmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] word,
	input  logic [15:0] modulus,
	output logic        done,
	output logic [15:0] result
);

	rd_state_t   state_q, state_d;
	logic [16:0] rem_q;
	logic [15:0] word_q;
	logic [15:0] mod_q;
	logic [3:0]  bit_q;
	logic [16:0] shifted;
	logic [16:0] trial;
	logic        done_q;

	assign shifted = {rem_q[15:0], word_q[bit_q]};
	assign trial   = shifted - {1'b0, mod_q};
	assign result  = rem_q[15:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			RD_IDLE: if (start) state_d = RD_RUN;
			RD_RUN: begin
				if (bit_q == 4'd0) begin
					state_d = RD_IDLE;
				end
			end
			default: state_d = RD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == RD_RUN) && (bit_q == 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RD_IDLE && start) begin
			word_q <= word;
			mod_q  <= modulus;
			rem_q  <= '0;
			bit_q  <= 4'd15;
		end else if (state_q == RD_RUN) begin
			// zero modulus leaves the raw word
			if (mod_q != 16'd0 && !trial[16]) rem_q <= trial;
			else rem_q <= shifted;
			bit_q <= bit_q - 4'd1;
		end
	end

	assign done = done_q;

endmodule

@@ design/shmx_back.sv @@
// ---------------------------------------------------------------------------
// shmx_back: compression and emit engine
// Runs SHA-256 one round per cycle with a 16-word schedule window, then
// reduces and emits the requested digest halfwords through an output register.
// ---------------------------------------------------------------------------
module shmx_back import shmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] modulus,
	input  logic        q_valid,
	output logic        q_take,
	input  desc_t       q_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_element,
	output logic        out_last
);

	bk_state_t   state_q, state_d;
	logic [31:0] w_q [16];
	logic [31:0] s_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  rnd_q;
	logic [4:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        busy_q;
	logic        ov_q;
	logic        start;
	logic        rdone;
	logic [15:0] rres;
	logic [15:0] word;
	logic [31:0] t1, t2, x0, x1, wnext, hsel;

	assign x0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign x1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnext = w_q[0] + x0 + w_q[9] + x1;
	assign t1 = s_q[7] + (ror(s_q[4], 6) ^ ror(s_q[4], 11) ^ ror(s_q[4], 25))
		+ ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + round_k(rnd_q) + w_q[0];
	assign t2 = (ror(s_q[0], 2) ^ ror(s_q[0], 13) ^ ror(s_q[0], 22))
		+ ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));

	assign hsel = h_q[idx_q[3:1]];
	assign word = idx_q[0] ? hsel[15:0] : hsel[31:16];
	assign start = (state_q == ST_EMIT) && !busy_q && !ov_q;
	assign out_valid = ov_q;

	shmx_reduce u_red (
		.clk(clk), .arst_n(arst_n), .start(start), .word(word),
		.modulus(modulus), .done(rdone), .result(rres)
	);

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		case (state_q)
			ST_IDLE: if (q_valid) begin
				q_take  = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_EMIT;
			ST_EMIT: if (rdone && (idx_q == cnt_q[3:0] - 4'd1 || cnt_q == 5'd16
				&& idx_q == 4'd15)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) busy_q <= 1'b1;
			else if (rdone) busy_q <= 1'b0;
			if (rdone) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdone) begin
			out_element <= rres;
			out_last    <= ({1'b0, idx_q} + 5'd1 == cnt_q);
			idx_q       <= idx_q + 4'd1;
		end
		case (state_q)
			ST_IDLE: begin
				w_q[0]  <= TAG_W0;
				w_q[1]  <= TAG_W1;
				w_q[2]  <= TAG_W2;
				w_q[3]  <= TAG_W3;
				w_q[4]  <= TAG_W4;
				w_q[5]  <= TAG_W5;
				w_q[6]  <= {TAG_TAIL, q_head.nonce[63:48]};
				w_q[7]  <= q_head.nonce[47:16];
				w_q[8]  <= {q_head.nonce[15:0], q_head.block_counter[63:48]};
				w_q[9]  <= q_head.block_counter[47:16];
				w_q[10] <= {q_head.block_counter[15:0], 16'h8000};
				w_q[11] <= '0;
				w_q[12] <= '0;
				w_q[13] <= '0;
				w_q[14] <= '0;
				w_q[15] <= LEN_BITS;
				for (int i = 0; i < 8; i++) s_q[i] <= init_h(3'(i));
				rnd_q <= '0;
				cnt_q <= q_head.count;
				idx_q <= '0;
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wnext;
				s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
				s_q[4] <= s_q[3] + t1;
				s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
				s_q[0] <= t1 + t2;
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					h_q[0] <= init_h(3'd0) + t1 + t2;
					h_q[1] <= init_h(3'd1) + s_q[0];
					h_q[2] <= init_h(3'd2) + s_q[1];
					h_q[3] <= init_h(3'd3) + s_q[2];
					h_q[4] <= init_h(3'd4) + s_q[3] + t1;
					h_q[5] <= init_h(3'd5) + s_q[4];
					h_q[6] <= init_h(3'd6) + s_q[5];
					h_q[7] <= init_h(3'd7) + s_q[6];
				end
			end
			default: ;
		endcase
	end

endmodule
